>>> rtl/ctdn_pkg.sv
// Shared types, constants and the digit pattern table of the countdown timer.
package ctdn_pkg;

   localparam int TimeWidth = 13;
   localparam int QuoWidth = 8;          // minutes field out of the divide chain
   localparam int DivCells = QuoWidth;   // one restoring step per quotient bit
   localparam int CsrIndexWidth = 2;

   localparam logic [TimeWidth-1:0] DisplayLimit = 13'd5999;
   localparam logic [TimeWidth-1:0] SecondsPerMinute = 13'd60;
   localparam logic [TimeWidth-1:0] LargeStepReset = 13'd60;
   localparam logic [TimeWidth-1:0] SmallStepReset = 13'd10;
   localparam logic [TimeWidth-1:0] MaxTimeReset = 13'd5999;

   // Register indexes of the write port
   localparam logic [CsrIndexWidth-1:0] CsrLargeStep = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSmallStep = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrMaxTime = 2'd2;

   // Beep codes
   localparam logic [1:0] BeepNone = 2'd0;
   localparam logic [1:0] BeepShort = 2'd1;
   localparam logic [1:0] BeepAlarm = 2'd2;

   // Scan positions
   localparam logic [1:0] ScanMinTens = 2'd0;
   localparam logic [1:0] ScanMinOnes = 2'd1;
   localparam logic [1:0] ScanSecTens = 2'd2;

   typedef struct packed {
      logic [TimeWidth-1:0] rem;
      logic [QuoWidth-1:0]  quo;
      logic [1:0]           scan;
      logic [1:0]           beep;
      logic                 running;
      logic [TimeWidth-1:0] shown;
   } item_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0: pat = 7'h3F;
         4'd1: pat = 7'h06;
         4'd2: pat = 7'h5B;
         4'd3: pat = 7'h4F;
         4'd4: pat = 7'h66;
         4'd5: pat = 7'h6D;
         4'd6: pat = 7'h7D;
         4'd7: pat = 7'h07;
         4'd8: pat = 7'h7F;
         default: pat = 7'h6F;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/ctdn_ctrl.sv
// Timer control: button edges, set/run state, countdown and the first pipeline register.
module ctdn_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_minute_button,
   input  logic                                 req_tens_button,
   input  logic                                 req_run_button,
   input  logic                                 req_second_tick,
   input  logic                                 req_scan_tick,
   input  logic                                 csr_write_enable,
   input  logic [ctdn_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ctdn_pkg::TimeWidth-1:0]       csr_wdata,
   output logic                                 out_valid,
   output ctdn_pkg::item_type                   out_item,
   input  logic                                 out_ready
);

   logic [ctdn_pkg::TimeWidth-1:0] large_ff, small_ff, max_ff;
   logic                           counting_ff, counting_in;
   logic [ctdn_pkg::TimeWidth-1:0] set_ff, set_in;
   logic [ctdn_pkg::TimeWidth-1:0] left_ff, left_in;
   logic [2:0]                     held_ff, held_in;
   logic [1:0]                     scan_ff, scan_in;
   logic [1:0]                     beep;
   logic                           valid_ff;
   ctdn_pkg::item_type             item_ff, item_in;
   logic                           accept;
   logic                           ready;

   function automatic logic [ctdn_pkg::TimeWidth-1:0] add_sat(
      input logic [ctdn_pkg::TimeWidth-1:0] base,
      input logic [ctdn_pkg::TimeWidth-1:0] step,
      input logic [ctdn_pkg::TimeWidth-1:0] limit
   );
      logic [ctdn_pkg::TimeWidth:0] sum;
      sum = {1'b0, base} + {1'b0, step};
      return (sum > {1'b0, limit}) ? limit : sum[ctdn_pkg::TimeWidth-1:0];
   endfunction

   assign ready = !valid_ff || out_ready;
   assign req_stall = !ready;
   assign accept = req_valid && ready;

   always_comb begin
      logic [ctdn_pkg::TimeWidth-1:0] limit;
      logic [ctdn_pkg::TimeWidth-1:0] set1, set2, left1;
      logic                           m_edge, t_edge, r_edge;
      limit = (max_ff > ctdn_pkg::DisplayLimit) ? ctdn_pkg::DisplayLimit : max_ff;
      set1 = set_ff;
      set2 = set_ff;
      left1 = left_ff;
      m_edge = req_minute_button && !held_ff[0];
      t_edge = req_tens_button && !held_ff[1];
      r_edge = req_run_button && !held_ff[2];
      counting_in = counting_ff;
      set_in = set_ff;
      left_in = left_ff;
      held_in = held_ff;
      beep = ctdn_pkg::BeepNone;
      if (!counting_ff) begin
         set1 = m_edge ? add_sat(set_ff, large_ff, limit) : set_ff;
         set2 = t_edge ? add_sat(set1, small_ff, limit) : set1;
         held_in[0] = req_minute_button;
         held_in[1] = req_tens_button;
         if (m_edge || t_edge) begin
            beep = ctdn_pkg::BeepShort;
         end
         // run button is ignored entirely while nothing is set
         if (set2 != '0) begin
            held_in[2] = req_run_button;
            if (r_edge) begin
               counting_in = 1'b1;
               beep = ctdn_pkg::BeepShort;
            end
         end
         set_in = set2;
         left_in = set2;
      end else begin
         if (req_second_tick && left_ff != '0) begin
            left1 = left_ff - 13'd1;
         end
         left_in = left1;
         if (left1 == '0) begin
            set_in = '0;
            counting_in = 1'b0;
            beep = ctdn_pkg::BeepAlarm;
         end else begin
            held_in[2] = req_run_button;
            if (r_edge) begin
               set_in = left1;
               counting_in = 1'b0;
               beep = ctdn_pkg::BeepShort;
            end
         end
      end
      scan_in = scan_ff + {1'b0, req_scan_tick};

      item_in.rem = left_in;
      item_in.quo = '0;
      item_in.scan = scan_ff;
      item_in.beep = beep;
      item_in.running = counting_in;
      item_in.shown = left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         large_ff <= ctdn_pkg::LargeStepReset;
         small_ff <= ctdn_pkg::SmallStepReset;
         max_ff <= ctdn_pkg::MaxTimeReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            ctdn_pkg::CsrLargeStep: large_ff <= csr_wdata;
            ctdn_pkg::CsrSmallStep: small_ff <= csr_wdata;
            ctdn_pkg::CsrMaxTime: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counting_ff <= 1'b0;
         set_ff <= '0;
         left_ff <= '0;
         held_ff <= '0;
         scan_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            counting_ff <= counting_in;
            set_ff <= set_in;
            left_ff <= left_in;
            held_ff <= held_in;
            scan_ff <= scan_in;
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

>>> rtl/ctdn_div_cell.sv
// One restoring divide-by-60 step with its own pipeline register.
module ctdn_div_cell #(
   parameter int Shift = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctdn_pkg::item_type in_item,
   output logic               out_valid,
   output ctdn_pkg::item_type out_item,
   input  logic               out_ready
);

   localparam logic [ctdn_pkg::TimeWidth-1:0] Divisor =
      ctdn_pkg::TimeWidth'(ctdn_pkg::SecondsPerMinute << Shift);

   logic               valid_ff;
   ctdn_pkg::item_type item_ff, item_in;

   always_comb begin
      item_in = in_item;
      if (in_item.rem >= Divisor) begin
         item_in.rem = in_item.rem - Divisor;
         item_in.quo[Shift] = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

>>> rtl/ctdn_seg_out.sv
// Digit split, segment lookup and the result register.
module ctdn_seg_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctdn_pkg::item_type in_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_segments,
   output logic [3:0]         rsp_digit_enable,
   output logic [1:0]         rsp_beep,
   output logic               rsp_running,
   output logic [12:0]        rsp_time_left
);

   logic        valid_ff;
   logic [6:0]  segments_ff, segments_in;
   logic [3:0]  enable_ff, enable_in;
   logic [1:0]  beep_ff;
   logic        running_ff;
   logic [12:0] left_ff;

   always_comb begin
      logic [15:0] min_prod;
      logic [13:0] sec_prod;
      logic [4:0]  min_tens;
      logic [7:0]  min_ones;
      logic [2:0]  sec_tens;
      logic [5:0]  sec_ones;
      logic [7:0]  digit;
      // x/10 as (x*205)>>11, exact for x below 1029
      min_prod = 16'(in_item.quo) * 16'd205;
      sec_prod = 14'(in_item.rem[5:0]) * 14'd205;
      min_tens = min_prod[15:11];
      sec_tens = sec_prod[13:11];
      min_ones = in_item.quo - 8'(min_tens) * 8'd10;
      sec_ones = in_item.rem[5:0] - 6'(sec_tens) * 6'd10;
      case (in_item.scan)
         ctdn_pkg::ScanMinTens: digit = 8'(min_tens);
         ctdn_pkg::ScanMinOnes: digit = min_ones;
         ctdn_pkg::ScanSecTens: digit = 8'(sec_tens);
         default: digit = 8'(sec_ones);
      endcase
      if (digit > 8'd9) begin
         digit = 8'd9;
      end
      segments_in = ctdn_pkg::seg_pattern(digit[3:0]);
      enable_in = 4'b0001 << in_item.scan;
   end

   assign in_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         segments_ff <= segments_in;
         enable_ff <= enable_in;
         beep_ff <= in_item.beep;
         running_ff <= in_item.running;
         left_ff <= in_item.shown;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_segments = segments_ff;
   assign rsp_digit_enable = enable_ff;
   assign rsp_beep = beep_ff;
   assign rsp_running = running_ff;
   assign rsp_time_left = left_ff;

endmodule

>>> rtl/countdown_timer_seven_segment.sv
// Countdown timer top: control, divide-by-60 cell chain and segment output stage.
// Pipeline: an accepted item passes the control register, 8 divide cells and the
// output register in that order; each stage holds one item.
// Throughput: one item per cycle while rsp_stall is low; a stage refills as soon as its successor moves on.
// Reset: synchronous; clears pipeline valids, timer state and scan position, and
// loads large_step 60, small_step 10, max_time 5999.
module countdown_timer_seven_segment (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_minute_button,
   input  logic        req_tens_button,
   input  logic        req_run_button,
   input  logic        req_second_tick,
   input  logic        req_scan_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_segments,
   output logic [3:0]  rsp_digit_enable,
   output logic [1:0]  rsp_beep,
   output logic        rsp_running,
   output logic [12:0] rsp_time_left,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic               chain_valid [ctdn_pkg::DivCells+1];
   logic               chain_ready [ctdn_pkg::DivCells+1];
   ctdn_pkg::item_type chain_item  [ctdn_pkg::DivCells+1];

   ctdn_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_minute_button (req_minute_button),
      .req_tens_button   (req_tens_button),
      .req_run_button    (req_run_button),
      .req_second_tick   (req_second_tick),
      .req_scan_tick     (req_scan_tick),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .out_valid         (chain_valid[0]),
      .out_item          (chain_item[0]),
      .out_ready         (chain_ready[0])
   );

   // highest quotient bit first
   for (genvar i = 0; i < ctdn_pkg::DivCells; i++) begin : g_cell
      ctdn_div_cell #(
         .Shift (ctdn_pkg::DivCells - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   ctdn_seg_out u_seg_out (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (chain_valid[ctdn_pkg::DivCells]),
      .in_ready         (chain_ready[ctdn_pkg::DivCells]),
      .in_item          (chain_item[ctdn_pkg::DivCells]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segments     (rsp_segments),
      .rsp_digit_enable (rsp_digit_enable),
      .rsp_beep         (rsp_beep),
      .rsp_running      (rsp_running),
      .rsp_time_left    (rsp_time_left)
   );

endmodule
